>>> design/edf_pkg.sv
// Shared types and constants for the earliest-deadline-first task scheduler.
// Used by the entry RAM user, the compare/decrement unit and the top level.
package edf_pkg;

    typedef enum logic [1:0] {
        MODE_DORMANT  = 2'd0,
        MODE_READY    = 2'd1,
        MODE_RUNNING  = 2'd2,
        MODE_SLEEPING = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_SCHED = 2'd1,
        ACT_START = 2'd2,
        ACT_WRITE = 2'd3
    } action_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_PICK = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic [31:0] ctx;
        logic [30:0] slice;
        logic [31:0] tleft;
        mode_t       mode;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam logic [31:0] TIME_MIN = 32'h8000_0000;

    typedef struct packed {
        alu_op_t     op;
        entry_t      ent;
        logic [31:0] best_time;
        logic        found;
        logic        allow_run;
    } alu_req_t;

    typedef struct packed {
        entry_t ent;
        logic   fired;
        logic   take;
    } alu_rsp_t;

endpackage

>>> design/edf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the task entries of the scheduler; depends on nothing else.
module edf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/edf_alu.sv
// Shared compare and decrement unit of the scheduler.
// Depends on edf_pkg for the entry and request types.
module edf_alu (
    input  edf_pkg::alu_req_t req,
    output edf_pkg::alu_rsp_t rsp
);

    logic [31:0] dec;
    logic        expired;
    logic        active;
    logic        eligible;

    always_comb begin
        dec = (req.ent.tleft == edf_pkg::TIME_MIN) ? req.ent.tleft : req.ent.tleft - 32'd1;
        expired = (dec == 32'd0) || dec[31];
        active = (req.ent.mode == edf_pkg::MODE_SLEEPING)
              || (req.ent.mode == edf_pkg::MODE_RUNNING);
        eligible = (req.ent.mode == edf_pkg::MODE_READY)
                || (req.allow_run && (req.ent.mode == edf_pkg::MODE_RUNNING));

        rsp.ent = req.ent;
        rsp.fired = 1'b0;
        rsp.take = 1'b0;
        case (req.op)
            edf_pkg::OP_TICK: begin
                if (expired && active) begin
                    rsp.ent.mode = edf_pkg::MODE_READY;
                    rsp.ent.tleft = {1'b0, req.ent.slice};
                    rsp.fired = 1'b1;
                end else begin
                    rsp.ent.tleft = dec;
                end
            end
            edf_pkg::OP_PICK: begin
                rsp.take = eligible
                        && (!req.found || ($signed(req.ent.tleft) < $signed(req.best_time)));
            end
            default: begin
                rsp.take = 1'b0;
            end
        endcase
    end

endmodule

>>> design/edf_task_scheduler.sv
// Earliest-deadline-first task scheduler: sequencer, task entry RAM and shared unit.
// Depends on edf_pkg, edf_ram and edf_alu.
//
// Usage: one command per transfer on the slave stream (tick, schedule, start or
// write of a task entry); every command yields exactly one result transfer on the
// master stream with the running task, its saved context and the event flags.
// The block takes one command at a time and is not ready while it works on it;
// it is ready again in the cycle after the result is loaded.
// Steps: a write stores the entry; a suppressed or unstarted tick stores nothing;
// an active tick decrements or reloads every entry's time; a start scans for the
// earliest ready deadline and marks that task running; a schedule first saves the
// running task's context, then scans and picks likewise. Every command ends by
// reading the running task for the result. Ticks and scans sweep the entries
// through the one read port of the RAM and the compare/decrement unit, one entry per cycle.
// After reset all tasks are dormant with zero times, slices and contexts, the
// null task runs and the scheduler is not started; valid bits make unwritten
// entries read as zero, so no clearing pass is needed.
// A finished result waits in the output register while the receiver stalls; the
// next command is taken meanwhile, and its result waits until the register frees.
module edf_task_scheduler #(
    parameter int TASK_COUNT = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tick_suppressed, saved_context, task_index, task_mode, task_time,
    // task_slice, task_context
    input  logic [135:0] s_axis_tdata,
    // action
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // current_task, next_context, switch_request, release_stack, released_task
    output logic [47:0]  m_axis_tdata
);

    localparam int IDX_W = $clog2(TASK_COUNT);
    localparam int CNT_W = $clog2(TASK_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TASK_COUNT);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_TICK,
        ST_SCH_RD,
        ST_SCH_UPD,
        ST_SCAN,
        ST_PICK_RD,
        ST_PICK_UPD,
        ST_FIN_RD,
        ST_FIN_WAIT
    } state_t;

    logic                  tick_suppressed;
    logic [31:0]           saved_context;
    logic [3:0]            task_index;
    edf_pkg::entry_t       in_ent;
    edf_pkg::action_t      action;

    state_t                st_reg, st_next;
    edf_pkg::action_t      act_reg, act_next;
    logic [31:0]           saved_reg, saved_next;
    logic [3:0]            tidx_reg, tidx_next;
    edf_pkg::entry_t       tent_reg, tent_next;
    logic [IDX_W-1:0]      run_reg, run_next;
    logic                  started_reg, started_next;
    logic [TASK_COUNT-1:0] vld_reg, vld_next;
    logic                  vld_rd_reg, vld_rd_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      pidx_reg, pidx_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [31:0]           best_time_reg, best_time_next;
    logic                  sw_reg, sw_next;
    logic                  rel_reg, rel_next;
    logic [IDX_W-1:0]      relt_reg, relt_next;
    logic                  m_valid_reg, m_valid_next;
    logic [47:0]           m_data_reg, m_data_next;

    logic                  s_acc;
    logic                  out_free;
    logic                  out_load;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [IDX_W-1:0]      ram_raddr;
    logic                  ram_re;
    edf_pkg::entry_t       ram_wdata;
    logic [edf_pkg::ENTRY_W-1:0] ram_rdata;
    edf_pkg::entry_t       rd_ent;
    edf_pkg::entry_t       upd_ent;
    edf_pkg::alu_req_t     alu_req;
    edf_pkg::alu_rsp_t     alu_rsp;

    assign action          = edf_pkg::action_t'(s_axis_tuser);
    assign tick_suppressed = s_axis_tdata[0];
    assign saved_context   = s_axis_tdata[32:1];
    assign task_index      = s_axis_tdata[36:33];
    assign in_ent.mode     = edf_pkg::mode_t'(s_axis_tdata[38:37]);
    assign in_ent.tleft    = s_axis_tdata[70:39];
    assign in_ent.slice    = s_axis_tdata[101:71];
    assign in_ent.ctx      = s_axis_tdata[133:102];

    assign s_axis_tready = (st_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign rd_ent = vld_rd_reg ? edf_pkg::entry_t'(ram_rdata) : '0;

    edf_ram #(
        .WIDTH (edf_pkg::ENTRY_W),
        .DEPTH (TASK_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    edf_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_comb begin
        st_next        = st_reg;
        act_next       = act_reg;
        saved_next     = saved_reg;
        tidx_next      = tidx_reg;
        tent_next      = tent_reg;
        run_next       = run_reg;
        started_next   = started_reg;
        vld_next       = vld_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pidx_next      = pidx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_time_next = best_time_reg;
        sw_next        = sw_reg;
        rel_next       = rel_reg;
        relt_next      = relt_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = pidx_reg;
        ram_wdata      = rd_ent;
        ram_re         = 1'b0;
        ram_raddr      = run_reg;
        upd_ent        = rd_ent;

        alu_req.op        = edf_pkg::OP_PICK;
        alu_req.ent       = rd_ent;
        alu_req.best_time = best_time_reg;
        alu_req.found     = found_reg;
        alu_req.allow_run = (act_reg == edf_pkg::ACT_SCHED);

        case (st_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    act_next      = action;
                    saved_next    = saved_context;
                    tidx_next     = task_index;
                    tent_next     = in_ent;
                    sw_next       = 1'b0;
                    rel_next      = 1'b0;
                    relt_next     = '0;
                    pend_next     = 1'b0;
                    found_next    = 1'b0;
                    best_idx_next = '0;
                    case (action)
                        edf_pkg::ACT_TICK: begin
                            cnt_next = '0;
                            st_next  = (!tick_suppressed && started_reg) ? ST_TICK : ST_FIN_RD;
                        end
                        edf_pkg::ACT_SCHED: begin
                            st_next = ST_SCH_RD;
                        end
                        edf_pkg::ACT_START: begin
                            cnt_next = CNT_W'(1);
                            st_next  = ST_SCAN;
                        end
                        default: begin
                            st_next = ST_WRITE;
                        end
                    endcase
                end
            end
            ST_WRITE: begin
                if (int'(tidx_reg) < TASK_COUNT) begin
                    ram_we              = 1'b1;
                    ram_waddr           = IDX_W'(tidx_reg);
                    ram_wdata           = tent_reg;
                    vld_next[ram_waddr] = 1'b1;
                end
                st_next = ST_FIN_RD;
            end
            ST_TICK: begin
                alu_req.op = edf_pkg::OP_TICK;
                if (cnt_reg < CNT_END) begin
                    ram_re    = 1'b1;
                    ram_raddr = cnt_reg[IDX_W-1:0];
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                pend_next = (cnt_reg < CNT_END);
                pidx_next = cnt_reg[IDX_W-1:0];
                if (pend_reg) begin
                    ram_we             = 1'b1;
                    ram_waddr          = pidx_reg;
                    ram_wdata          = alu_rsp.ent;
                    vld_next[pidx_reg] = 1'b1;
                    if (alu_rsp.fired) begin
                        sw_next = 1'b1;
                    end
                end
                if (!pend_reg && (cnt_reg == CNT_END)) begin
                    st_next = ST_FIN_RD;
                end
            end
            ST_SCH_RD: begin
                ram_re    = 1'b1;
                ram_raddr = run_reg;
                st_next   = ST_SCH_UPD;
            end
            ST_SCH_UPD: begin
                upd_ent.ctx = saved_reg;
                if (rd_ent.mode == edf_pkg::MODE_RUNNING) begin
                    upd_ent.mode = edf_pkg::MODE_READY;
                end
                if (rd_ent.mode == edf_pkg::MODE_DORMANT) begin
                    rel_next  = 1'b1;
                    relt_next = run_reg;
                end
                ram_we            = 1'b1;
                ram_waddr         = run_reg;
                ram_wdata         = upd_ent;
                vld_next[run_reg] = 1'b1;
                cnt_next          = CNT_W'(1);
                st_next           = ST_SCAN;
            end
            ST_SCAN: begin
                if (cnt_reg < CNT_END) begin
                    ram_re    = 1'b1;
                    ram_raddr = cnt_reg[IDX_W-1:0];
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                pend_next = (cnt_reg < CNT_END);
                pidx_next = cnt_reg[IDX_W-1:0];
                if (pend_reg && alu_rsp.take) begin
                    found_next     = 1'b1;
                    best_idx_next  = pidx_reg;
                    best_time_next = rd_ent.tleft;
                end
                if (!pend_reg && (cnt_reg == CNT_END)) begin
                    st_next = ST_PICK_RD;
                end
            end
            ST_PICK_RD: begin
                ram_re    = 1'b1;
                ram_raddr = best_idx_reg;
                st_next   = ST_PICK_UPD;
            end
            ST_PICK_UPD: begin
                upd_ent.mode           = edf_pkg::MODE_RUNNING;
                ram_we                 = 1'b1;
                ram_waddr              = best_idx_reg;
                ram_wdata              = upd_ent;
                vld_next[best_idx_reg] = 1'b1;
                run_next               = best_idx_reg;
                if (act_reg == edf_pkg::ACT_START) begin
                    started_next = 1'b1;
                end
                st_next = ST_FIN_RD;
            end
            ST_FIN_RD: begin
                ram_re    = 1'b1;
                ram_raddr = run_reg;
                st_next   = ST_FIN_WAIT;
            end
            ST_FIN_WAIT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, 4'(relt_reg), rel_reg, sw_reg, rd_ent.ctx,
                                    4'(run_reg)};
                    st_next      = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase

        vld_rd_next = ram_re ? vld_reg[ram_raddr] : vld_rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            run_reg     <= '0;
            started_reg <= 1'b0;
            vld_reg     <= '0;
            vld_rd_reg  <= 1'b0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            run_reg     <= run_next;
            started_reg <= started_next;
            vld_reg     <= vld_next;
            vld_rd_reg  <= vld_rd_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg       <= act_next;
        saved_reg     <= saved_next;
        tidx_reg      <= tidx_next;
        tent_reg      <= tent_next;
        pidx_reg      <= pidx_next;
        found_reg     <= found_next;
        best_idx_reg  <= best_idx_next;
        best_time_reg <= best_time_next;
        sw_reg        <= sw_next;
        rel_reg       <= rel_next;
        relt_reg      <= relt_next;
        m_data_reg    <= m_data_next;
    end

    // Ready drops after a command is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_axis_tready)
        else $error("edf: ready did not drop after an input transfer");

    // The entry RAM is never written while the block waits for a command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_IDLE) |-> !ram_we)
        else $error("edf: entry RAM written while idle");

    // The sweep counter never passes the table size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_END)
        else $error("edf: sweep counter out of range");

    // A stack release is only reported for a schedule command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && rel_reg) |-> (act_reg == edf_pkg::ACT_SCHED))
        else $error("edf: stack release reported outside a schedule");

    // A switch request is only reported for a tick command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && sw_reg) |-> (act_reg == edf_pkg::ACT_TICK))
        else $error("edf: switch request reported outside a tick");

endmodule
